@@ src/irtx_pkg.sv @@
// ----------------------------------------------------------------------------
// irtx_pkg
// Shared constants, register map and symbol tables of the ir remote command
// transmitter.
// ----------------------------------------------------------------------------
package irtx_pkg;

  localparam int NumButtons = 6;
  localparam int TimeWidth  = 16;
  localparam int CfgWidth   = 16;
  localparam int CfgIdxW    = 3;
  localparam int SymIdxW    = 4;

  localparam logic [CfgIdxW-1:0] RegStartMark  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOffSpace   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffMark    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOnMark     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFramePeriod = 3'd4;

  localparam logic [CfgWidth-1:0] StartMarkReset   = 16'd1739;
  localparam logic [CfgWidth-1:0] OffSpaceReset    = 16'd270;
  localparam logic [CfgWidth-1:0] OffMarkReset     = 16'd400;
  localparam logic [CfgWidth-1:0] OnMarkReset      = 16'd640;
  localparam logic [CfgWidth-1:0] FramePeriodReset = 16'd500;

  localparam logic [SymIdxW-1:0] CmdSymbols = 4'd7;

  localparam logic [1:0] ChanOne   = 2'd0;
  localparam logic [1:0] ChanTwo   = 2'd1;
  localparam logic [1:0] ChanThree = 2'd2;
  localparam logic [1:0] ChanFour  = 2'd3;

  // symbol position of the single on symbol among the command symbols
  function automatic logic [SymIdxW-1:0] on_position(input logic [2:0] cmd);
    logic [SymIdxW-1:0] pos;
    case (cmd)
      3'd0:    pos = 4'd1;
      3'd1:    pos = 4'd4;
      3'd2:    pos = 4'd2;
      3'd3:    pos = 4'd3;
      3'd4:    pos = 4'd5;
      3'd5:    pos = 4'd5;
      default: pos = 4'd6;
    endcase
    return pos;
  endfunction

  // bit k is suffix symbol k
  function automatic logic [4:0] suffix_bits(input logic [1:0] chan);
    logic [4:0] bits;
    case (chan)
      ChanOne:   bits = 5'h15;
      ChanTwo:   bits = 5'h04;
      ChanThree: bits = 5'h01;
      default:   bits = 5'h02;
    endcase
    return bits;
  endfunction

  function automatic logic [SymIdxW-1:0] suffix_len(input logic [1:0] chan);
    return (chan == ChanOne) ? 4'd5 : 4'd3;
  endfunction

endpackage

@@ src/irtx_if.sv @@
// ----------------------------------------------------------------------------
// irtx_if
// Valid/ready channels of the ir remote command transmitter: timer tick
// words in, transmitter status words out.
// ----------------------------------------------------------------------------
interface irtx_in_if #(
  parameter int NUM_BUTTONS = irtx_pkg::NumButtons
);
  logic                   valid;
  logic                   ready;
  logic                   sys_tick;
  logic [NUM_BUTTONS-1:0] buttons_pressed;
  logic [2:0]             channel_switches;

  modport source (output valid, sys_tick, buttons_pressed, channel_switches, input ready);
  modport sink   (input valid, sys_tick, buttons_pressed, channel_switches, output ready);
endinterface

interface irtx_out_if #(
  parameter int CMD_W = $clog2(irtx_pkg::NumButtons + 1)
);
  logic             valid;
  logic             ready;
  logic             carrier_enable;
  logic             frame_busy;
  logic             blink_level;
  logic [CMD_W-1:0] command_in_flight;

  modport source (output valid, carrier_enable, frame_busy, blink_level,
                  command_in_flight, input ready);
  modport sink   (input valid, carrier_enable, frame_busy, blink_level,
                  command_in_flight, output ready);
endinterface

@@ src/ir_remote_command_transmitter_top.sv @@
// ----------------------------------------------------------------------------
// ir_remote_command_transmitter_top
// Ir remote frame sequencer: button scan, frame period and blink, start
// mark, command symbols and channel suffix, one status word per timer tick.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  in_i     | in  | sys_tick, buttons_pressed, channel_switches
//  out_o    | out | carrier_enable, frame_busy, blink_level, command_in_flight
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// one word per cycle unless a held result stalls the input; the status word is registered in the cycle after accept
// the next-state logic of the frame sequencer is combinational
// in_i.ready is low only while a result is held and out_o.ready is low
// reset restores register defaults, idle sequencer, no command pending
module ir_remote_command_transmitter_top #(
  parameter int NUM_BUTTONS = irtx_pkg::NumButtons,
  parameter int TIME_WIDTH  = irtx_pkg::TimeWidth,
  parameter int CMD_W       = $clog2(NUM_BUTTONS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  irtx_in_if.sink                       in_i,
  irtx_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [irtx_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irtx_pkg::CfgWidth-1:0] cfg_wdata_i
);

  localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int SW   = irtx_pkg::SymIdxW;
  localparam int CW   = irtx_pkg::CfgWidth;
  localparam logic [CMD_W-1:0] CmdNone = CMD_W'(NUM_BUTTONS);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_SPACE = 2'd2,
    PH_MARK  = 2'd3
  } phase_e;

  logic [CW-1:0] start_mark_q, off_space_q, off_mark_q, on_mark_q, period_cfg_q;

  logic [TIME_WIDTH-1:0] period_q, period_d;
  logic [CMD_W-1:0]      cur_q, cur_d, pend_q, pend_d;
  logic [SW-1:0]         idx_q, idx_d;
  phase_e                phase_q, phase_d;
  logic [TIME_WIDTH-1:0] dur_q, dur_d;
  logic [1:0]            chan_q, chan_d;
  logic                  blink_q, blink_d;

  logic                  out_valid_q;
  logic                  carrier_q, busy_q, blink_out_q;
  logic [CMD_W-1:0]      cmd_out_q;

  logic                  accept;
  logic [CMD_W-1:0]      scan_start, scan_cmd;
  logic [IdxW:0]         scan_pos;
  logic [TIME_WIDTH-1:0] period_inc;
  logic [CMD_W-1:0]      pend_inc;
  logic                  launch;
  logic [TIME_WIDTH-1:0] dur_cnt;
  logic [SW-1:0]         next_idx, sfx_pos;
  logic [4:0]            sfx_bits;
  logic [1:0]            prio_chan, next_chan;
  logic [3:0]            cur_ext;
  logic                  sym_on, frame_end;
  logic                  carrier_d, busy_d;
  logic [CMD_W-1:0]      cmd_out_d;

  function automatic logic [TIME_WIDTH-1:0] to_time(input logic [CW-1:0] v);
    logic [TIME_WIDTH+CW-1:0] ext;
    ext = {{TIME_WIDTH{1'b0}}, v};
    return ext[TIME_WIDTH-1:0];
  endfunction

  function automatic logic [TIME_WIDTH-1:0] load_time(input logic [CW-1:0] v);
    logic [TIME_WIDTH-1:0] t;
    t = to_time(v);
    return (t == '0) ? TIME_WIDTH'(1) : t;
  endfunction

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;

  // round-robin scan starting after the last command sent
  assign scan_start = (cur_q >= CMD_W'(NUM_BUTTONS - 1)) ? '0 : cur_q + CMD_W'(1);

  always_comb begin
    scan_cmd = CmdNone;
    scan_pos = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      scan_pos = (IdxW+1)'(scan_start) + (IdxW+1)'(i);
      if (scan_pos >= (IdxW+1)'(NUM_BUTTONS)) begin
        scan_pos = scan_pos - (IdxW+1)'(NUM_BUTTONS);
      end
      if (in_i.buttons_pressed[scan_pos[IdxW-1:0]]) begin
        scan_cmd = CMD_W'(scan_pos[IdxW-1:0]);
      end
    end
  end

  always_comb begin
    if (in_i.channel_switches[0]) begin
      prio_chan = irtx_pkg::ChanTwo;
    end else if (in_i.channel_switches[1]) begin
      prio_chan = irtx_pkg::ChanThree;
    end else if (in_i.channel_switches[2]) begin
      prio_chan = irtx_pkg::ChanFour;
    end else begin
      prio_chan = irtx_pkg::ChanOne;
    end
  end

  assign period_inc = (in_i.sys_tick && period_q != '1) ? period_q + TIME_WIDTH'(1)
                                                         : period_q;
  assign pend_inc   = (in_i.sys_tick && pend_q == CmdNone) ? scan_cmd : pend_q;
  assign launch     = (phase_q == PH_IDLE) && (period_inc >= to_time(period_cfg_q));

  always_comb begin
    period_d  = period_inc;
    pend_d    = pend_inc;
    cur_d     = cur_q;
    blink_d   = blink_q;
    phase_d   = phase_q;
    idx_d     = idx_q;
    dur_d     = dur_q;
    chan_d    = chan_q;
    next_idx  = '0;
    next_chan = chan_q;
    sfx_pos   = '0;
    sfx_bits  = '0;
    sym_on    = 1'b0;
    frame_end = 1'b0;
    cur_ext   = '0;
    dur_cnt   = '0;

    // frame launch at the end of a period
    if (launch) begin
      period_d = '0;
      blink_d  = !blink_q;
      cur_d    = pend_inc;
      pend_d   = CmdNone;
      if (pend_inc != CmdNone) begin
        phase_d = PH_START;
        idx_d   = '0;
        dur_d   = load_time(start_mark_q);
      end
    end

    busy_d    = phase_d != PH_IDLE;
    carrier_d = (phase_d == PH_START) || (phase_d == PH_MARK);
    cmd_out_d = busy_d ? cur_d : CmdNone;

    // segment countdown and symbol sequencing
    if (busy_d) begin
      dur_cnt = (dur_d != '0) ? dur_d - TIME_WIDTH'(1) : dur_d;
      dur_d   = dur_cnt;
      if (dur_cnt == '0) begin
        if (phase_d == PH_SPACE) begin
          phase_d = PH_MARK;
          dur_d   = load_time(off_mark_q);
        end else begin
          next_idx  = (phase_d == PH_START) ? '0 : idx_d + SW'(1);
          next_chan = (next_idx == irtx_pkg::CmdSymbols) ? prio_chan : chan_d;
          frame_end = next_idx >= irtx_pkg::CmdSymbols + irtx_pkg::suffix_len(next_chan);
          sfx_pos   = next_idx - irtx_pkg::CmdSymbols;
          sfx_bits  = irtx_pkg::suffix_bits(next_chan);
          cur_ext   = 4'(cur_d);
          if (next_idx < irtx_pkg::CmdSymbols) begin
            sym_on = next_idx == irtx_pkg::on_position(cur_ext[2:0]);
          end else begin
            sym_on = sfx_bits[sfx_pos[2:0]];
          end
          idx_d  = next_idx;
          chan_d = next_chan;
          if (frame_end) begin
            phase_d = PH_IDLE;
            dur_d   = '0;
          end else if (sym_on) begin
            phase_d = PH_MARK;
            dur_d   = load_time(on_mark_q);
          end else begin
            phase_d = PH_SPACE;
            dur_d   = load_time(off_space_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mark_q <= irtx_pkg::StartMarkReset;
      off_space_q  <= irtx_pkg::OffSpaceReset;
      off_mark_q   <= irtx_pkg::OffMarkReset;
      on_mark_q    <= irtx_pkg::OnMarkReset;
      period_cfg_q <= irtx_pkg::FramePeriodReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        irtx_pkg::RegStartMark:   start_mark_q <= cfg_wdata_i;
        irtx_pkg::RegOffSpace:    off_space_q  <= cfg_wdata_i;
        irtx_pkg::RegOffMark:     off_mark_q   <= cfg_wdata_i;
        irtx_pkg::RegOnMark:      on_mark_q    <= cfg_wdata_i;
        irtx_pkg::RegFramePeriod: period_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      cur_q    <= CmdNone;
      pend_q   <= CmdNone;
      idx_q    <= '0;
      phase_q  <= PH_IDLE;
      dur_q    <= '0;
      chan_q   <= irtx_pkg::ChanOne;
      blink_q  <= 1'b0;
    end else if (accept) begin
      period_q <= period_d;
      cur_q    <= cur_d;
      pend_q   <= pend_d;
      idx_q    <= idx_d;
      phase_q  <= phase_d;
      dur_q    <= dur_d;
      chan_q   <= chan_d;
      blink_q  <= blink_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      carrier_q   <= carrier_d;
      busy_q      <= busy_d;
      blink_out_q <= blink_d;
      cmd_out_q   <= cmd_out_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.carrier_enable    = carrier_q;
  assign out_o.frame_busy        = busy_q;
  assign out_o.blink_level       = blink_out_q;
  assign out_o.command_in_flight = cmd_out_q;

endmodule

@@ src/irtx_checker.sv @@
// ----------------------------------------------------------------------------
// irtx_checker
// Port level checks of the ir remote command transmitter, bound to the top.
// ----------------------------------------------------------------------------
module irtx_checker #(
  parameter int NUM_BUTTONS = irtx_pkg::NumButtons,
  parameter int CMD_W       = $clog2(NUM_BUTTONS + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             carrier_i,
  input logic             busy_i,
  input logic             blink_i,
  input logic [CMD_W-1:0] cmd_i
);

  localparam logic [CMD_W-1:0] CmdNone = CMD_W'(NUM_BUTTONS);

  // held word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable({carrier_i, busy_i, blink_i, cmd_i}))
    else $error("held status word changed");

  // every accepted tick gives a word in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted tick produced no status word");

  // an empty output stage never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output stage");

  // carrier and command only during a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !busy_i |-> !carrier_i && (cmd_i == CmdNone))
    else $error("carrier or command outside a frame");

endmodule

bind ir_remote_command_transmitter_top irtx_checker #(
  .NUM_BUTTONS (NUM_BUTTONS),
  .CMD_W       (CMD_W)
) u_irtx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .carrier_i   (out_o.carrier_enable),
  .busy_i      (out_o.frame_busy),
  .blink_i     (out_o.blink_level),
  .cmd_i       (out_o.command_in_flight)
);

@@ verif/irtx_status_checker.sv @@
// ----------------------------------------------------------------------------
// irtx_status_checker
// Watches the timer tick words, the register writes and the status words of
// the ir remote command transmitter. Keeps its own model of the frame
// sequencer, queues the status word expected for every accepted tick word and
// compares each accepted status word field by field with the oldest one.
// ----------------------------------------------------------------------------
module irtx_status_checker
  import irtx_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  irtx_in_if                  words_in,
  irtx_out_if                 status_out,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         words_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {SegIdle, SegStart, SegSpace, SegMark} seg_e;
  typedef enum logic [1:0] {Ch1, Ch2, Ch3, Ch4} chan_e;

  typedef struct packed {
    logic       carrier;
    logic       busy;
    logic       blink;
    logic [2:0] cmd;
  } status_t;

  localparam logic [2:0] CmdNone      = 3'(NumButtons);
  localparam logic [3:0] FrameSymbols = 4'd7;
  localparam logic [3:0] OnSlot [8]   = '{4'd1, 4'd4, 4'd2, 4'd3, 4'd5, 4'd5, 4'd6, 4'd6};
  localparam logic [4:0] SuffixPat [4] = '{5'h15, 5'h04, 5'h01, 5'h02};

  logic [15:0] reg_start, reg_space, reg_offmark, reg_onmark, reg_period;
  logic [15:0] systicks;
  logic [15:0] left;
  logic [2:0]  sent_cmd, queued_cmd;
  logic [3:0]  slot;
  seg_e        seg;
  chan_e       chan;
  logic        blink;
  status_t     status_due [$];

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // round robin, starting after the command last sent
  function automatic logic [2:0] scan_from(input logic [NumButtons-1:0] pressed);
    int first;
    int b;
    first = (sent_cmd >= CmdNone) ? 0 : (int'(sent_cmd) + 1) % NumButtons;
    for (int i = 0; i < NumButtons; i++) begin
      b = (first + i) % NumButtons;
      if (pressed[b]) return 3'(b);
    end
    return CmdNone;
  endfunction

  task automatic clear_state();
    reg_start   = 16'd1739;
    reg_space   = 16'd270;
    reg_offmark = 16'd400;
    reg_onmark  = 16'd640;
    reg_period  = 16'd500;
    systicks    = 16'd0;
    left        = 16'd0;
    sent_cmd    = CmdNone;
    queued_cmd  = CmdNone;
    slot        = 4'd0;
    seg         = SegIdle;
    chan        = Ch1;
    blink       = 1'b0;
  endtask

  task automatic report_mismatch(input string line);
    $display("%0t ns: %s", $time, line);
    fail_count_o++;
  endtask

  task automatic compare_field(input string name, input logic [2:0] got,
                               input logic [2:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  task automatic open_symbol(input logic [2:0] sw);
    logic       lit;
    logic [3:0] span;
    // switches are sampled where the channel suffix begins
    if (slot == FrameSymbols) begin
      if (sw[0]) chan = Ch2;
      else if (sw[1]) chan = Ch3;
      else if (sw[2]) chan = Ch4;
      else chan = Ch1;
    end
    span = (chan == Ch1) ? 4'd5 : 4'd3;
    if (slot >= FrameSymbols + span) begin
      seg  = SegIdle;
      left = 16'd0;
      return;
    end
    if (slot < FrameSymbols) lit = (slot == OnSlot[sent_cmd]);
    else lit = SuffixPat[chan][slot - FrameSymbols];
    if (lit) begin
      seg  = SegMark;
      left = at_least_one(reg_onmark);
    end else begin
      seg  = SegSpace;
      left = at_least_one(reg_space);
    end
  endtask

  task automatic advance_tick(input logic tick, input logic [NumButtons-1:0] pressed,
                              input logic [2:0] sw);
    status_t want;
    logic    busy;
    if (tick) begin
      if (systicks != 16'hFFFF) systicks++;
      if (queued_cmd == CmdNone) queued_cmd = scan_from(pressed);
    end
    if (seg == SegIdle && systicks >= reg_period) begin
      systicks   = 16'd0;
      blink      = ~blink;
      sent_cmd   = queued_cmd;
      queued_cmd = CmdNone;
      if (sent_cmd != CmdNone) begin
        seg  = SegStart;
        slot = 4'd0;
        left = at_least_one(reg_start);
      end
    end
    busy         = (seg != SegIdle);
    want.carrier = (seg == SegStart || seg == SegMark);
    want.busy    = busy;
    want.blink   = blink;
    want.cmd     = busy ? sent_cmd : CmdNone;
    status_due.push_back(want);
    if (busy) begin
      if (left != 16'd0) left--;
      if (left == 16'd0) begin
        case (seg)
          SegStart: begin
            slot = 4'd0;
            open_symbol(sw);
          end
          SegSpace: begin
            seg  = SegMark;
            left = at_least_one(reg_offmark);
          end
          default: begin
            slot = slot + 4'd1;
            open_symbol(sw);
          end
        endcase
      end
    end
  endtask

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgWidth-1:0] val);
    case (idx)
      RegStartMark:   reg_start   = val;
      RegOffSpace:    reg_space   = val;
      RegOffMark:     reg_offmark = val;
      RegOnMark:      reg_onmark  = val;
      RegFramePeriod: reg_period  = val;
      default: ;
    endcase
  endtask

  task automatic check_status();
    status_t want;
    if (status_due.size() == 0) begin
      report_mismatch($sformatf("status word with none expected: carrier %0b busy %0b cmd %0d",
                                status_out.carrier_enable, status_out.frame_busy,
                                status_out.command_in_flight));
      return;
    end
    want = status_due.pop_front();
    compare_field("carrier_enable", 3'(status_out.carrier_enable), 3'(want.carrier));
    compare_field("frame_busy", 3'(status_out.frame_busy), 3'(want.busy));
    compare_field("blink_level", 3'(status_out.blink_level), 3'(want.blink));
    compare_field("command_in_flight", status_out.command_in_flight, want.cmd);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      status_due.delete();
      fail_count_o = 0;
      words_due_o <= 0;
    end else begin
      if (status_out.valid && status_out.ready) check_status();
      if (words_in.valid && words_in.ready) begin
        advance_tick(words_in.sys_tick, words_in.buttons_pressed, words_in.channel_switches);
      end
      // a register written at this edge counts from the next word on
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_wdata_i);
      words_due_o <= status_due.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives timer tick words into the ir remote command transmitter with random
// gaps and random stalls on the status side, steps the timing registers
// through zero, minimum, maximum and random small settings between phases,
// and leaves all prediction and comparison to the status checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import irtx_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgWidth-1:0] cfg_wdata_i;
  int unsigned         mismatches;
  int unsigned         words_due;
  bit                  calm;
  int unsigned         random_words;

  irtx_in_if  in_if ();
  irtx_out_if out_if ();

  ir_remote_command_transmitter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  irtx_status_checker u_status_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .words_in     (in_if),
    .status_out   (out_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (mismatches),
    .words_due_o  (words_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_word(input logic tick, input logic [NumButtons-1:0] pressed,
                           input logic [2:0] sw);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.sys_tick         <= tick;
    in_if.buttons_pressed  <= pressed;
    in_if.channel_switches <= sw;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain_words();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgWidth-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [CfgWidth-1:0] start_v, space_v, offmark_v,
                           onmark_v, period_v);
    put_reg(RegStartMark, start_v);
    put_reg(RegOffSpace, space_v);
    put_reg(RegOffMark, offmark_v);
    put_reg(RegOnMark, onmark_v);
    put_reg(RegFramePeriod, period_v);
  endtask

  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  initial begin
    int k;
    int span;
    int tick_pct;
    logic [NumButtons-1:0] held_buttons;
    logic [2:0] held_sw;
    in_if.valid            <= 1'b0;
    in_if.sys_tick         <= 1'b0;
    in_if.buttons_pressed  <= '0;
    in_if.channel_switches <= '0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= RegStartMark;
    cfg_wdata_i            <= '0;
    rst_ni                 <= 1'b0;
    calm = 1'b0;
    held_buttons = '0;
    held_sw = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero durations are loaded as one, zero period launches whenever idle
    load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    put_reg(RegSpareLo, 16'hFFFF);
    put_reg(RegSpareHi, 16'h0001);
    cfg_we_i <= 1'b0;
    for (k = 0; k < 24; k++) begin
      send_word(k % 3 != 2,
                (k < 6) ? 6'(1 << k) : (((k % 2) != 0) ? 6'h3F : 6'h00), 3'(k));
    end
    drain_words();

    // let the running frame finish, then hold everything at the top of the range
    load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
    cfg_we_i <= 1'b0;
    for (k = 0; k < 40; k++) send_word(1'($urandom), 6'($urandom), 3'($urandom));
    drain_words();
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    cfg_we_i <= 1'b0;
    for (k = 0; k < 60; k++) send_word(1'($urandom), 6'($urandom), 3'($urandom));
    drain_words();

    random_words = 0;
    while (random_words < 1250) begin
      case ($urandom_range(0, 9))
        0: load_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        1: load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        default: load_regs(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 12)));
      endcase
      cfg_we_i <= 1'b0;
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0: tick_pct = 100;
        1: tick_pct = 50;
        default: tick_pct = 15;
      endcase
      span = $urandom_range(40, 160);
      for (k = 0; k < span; k++) begin
        // buttons are held for a while, like real presses
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: held_buttons = '0;
            1, 2: held_buttons = 6'(1 << $urandom_range(0, NumButtons - 1));
            default: held_buttons = 6'($urandom);
          endcase
        end
        if ($urandom_range(0, 15) == 0) held_sw = 3'($urandom);
        send_word($urandom_range(1, 100) <= tick_pct, held_buttons, held_sw);
      end
      random_words += span;
      drain_words();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && words_due == 0) begin
      $display("ir_remote_command_transmitter_top: match");
    end else begin
      $display("ir_remote_command_transmitter_top: mismatch");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("ir_remote_command_transmitter_top: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
src/irtx_pkg.sv
src/irtx_if.sv
src/ir_remote_command_transmitter_top.sv
src/irtx_checker.sv
verif/irtx_status_checker.sv
verif/testbench.sv
